>>> sv/dtt_pkg.sv
// ---------------------------------------------------------------------------
// dtt_pkg
// shared types, constants and helpers of the deadline timer table
// ---------------------------------------------------------------------------
package dtt_pkg;

    localparam int unsigned TimerSlots = 16;
    localparam int unsigned SlotW      = 4;
    localparam int unsigned TimeW      = 48;
    localparam int unsigned PeriodW    = 32;
    localparam int unsigned CntW       = SlotW + 1;

    localparam logic [PeriodW-1:0] RolloverDefault = 32'd3600000;
    localparam logic [TimeW-1:0]   TimeMax         = {TimeW{1'b1}};

    typedef logic [SlotW-1:0]   slot_t;
    typedef logic [TimeW-1:0]   time_t;
    typedef logic [PeriodW-1:0] period_t;
    typedef logic [TimerSlots-1:0] slot_mask_t;

    typedef enum logic [2:0] {
        CMD_ADD     = 3'd0,
        CMD_CANCEL  = 3'd1,
        CMD_REFRESH = 3'd2,
        CMD_RESET   = 3'd3,
        CMD_COLLECT = 3'd4,
        CMD_QUERY   = 3'd5
    } command_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_INACTIVE = 2'd1,
        ST_FULL     = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_NOTICE,
        S_DUE,
        S_MIN,
        S_OUT
    } state_t;

    typedef struct packed {
        logic [2:0] command;
        slot_t      slot;
        period_t    interval_ms;
        logic       recurring;
        logic       restart_now;
        time_t      now_ms;
    } item_t;

    typedef struct packed {
        logic [1:0] status;
        slot_t      result_slot;
        logic       fired;
        time_t      wait_ms;
        logic       front_notice;
        logic       last;
    } result_t;

    typedef struct packed {
        logic    dl_en;
        logic    per_en;
        slot_t   addr;
        time_t   deadline;
        period_t period;
    } store_wr_t;

    function automatic time_t sat_add(input time_t a, input period_t b);
        logic [TimeW:0] s;
        s = {1'b0, a} + {{(TimeW + 1 - PeriodW){1'b0}}, b};
        return s[TimeW] ? TimeMax : s[TimeW-1:0];
    endfunction

endpackage

>>> sv/dtt_if.sv
// ---------------------------------------------------------------------------
// dtt_cmd_if / dtt_res_if
// valid/ready channels for commands and results
// ---------------------------------------------------------------------------
interface dtt_cmd_if;
    import dtt_pkg::*;
    logic  valid;
    logic  ready;
    item_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface dtt_res_if;
    import dtt_pkg::*;
    logic    valid;
    logic    ready;
    result_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

>>> sv/dtt_store.sv
// ---------------------------------------------------------------------------
// dtt_store
// deadline and period memories, one write and one registered read per cycle
// ---------------------------------------------------------------------------
module dtt_store (
    input  logic                clk,
    input  dtt_pkg::slot_t      rd_addr,
    output dtt_pkg::time_t      rd_deadline,
    output dtt_pkg::period_t    rd_period,
    input  dtt_pkg::store_wr_t  wr
);
    import dtt_pkg::*;

    time_t   deadline_mem [TimerSlots];
    period_t period_mem   [TimerSlots];
    time_t   rd_deadline_reg;
    period_t rd_period_reg;

    always_ff @(posedge clk)
    begin
        if (wr.dl_en)
        begin
            deadline_mem[wr.addr] <= wr.deadline;
        end
        if (wr.per_en)
        begin
            period_mem[wr.addr] <= wr.period;
        end
        rd_deadline_reg <= deadline_mem[rd_addr];
        rd_period_reg   <= period_mem[rd_addr];
    end

    assign rd_deadline = rd_deadline_reg;
    assign rd_period   = rd_period_reg;

endmodule

>>> sv/deadline_timer_table_core.sv
// ---------------------------------------------------------------------------
// deadline_timer_table_core
// sixteen timer slots with deadlines in memory, ordered expiry by scanning
// ---------------------------------------------------------------------------
// channel   dir  payload
// cmd_in    in   command, slot, interval_ms, recurring, restart_now, now_ms
// res_out   out  status, result_slot, fired, wait_ms, front_notice, last
// cfg_we    in   rollover_window_ms write (cfg_wdata)
//
// cancel, refresh, simple reset and table-full add go straight from decode to output
// add and reset with a notice check, and query on a non-empty table, make one
// pass over the deadline memory; collect on a non-empty table makes one pass plus one
// more pass per expired slot emitted
// a held result output stalls the sequencer; the next transfer is taken
// once the previous item is fully emitted
// ---------------------------------------------------------------------------
module deadline_timer_table_core (
    input  logic              clk,
    input  logic              rst_n,
    dtt_cmd_if.sink           cmd_in,
    dtt_res_if.source         res_out,
    input  logic              cfg_we,
    input  dtt_pkg::period_t  cfg_wdata
);
    import dtt_pkg::*;

    state_t     state_reg, state_next;
    item_t      item_reg, item_next;
    slot_mask_t active_reg, active_next;
    slot_mask_t repeats_reg, repeats_next;
    time_t      prev_now_reg, prev_now_next;
    logic       notified_reg, notified_next;
    period_t    window_reg;
    logic       out_v_reg, out_v_next;
    result_t    out_reg, out_next;

    logic [CntW-1:0] cnt_reg, cnt_next;
    slot_mask_t mask_reg, mask_next;
    logic       fail_reg, fail_next;
    logic       bfound_reg, bfound_next;
    time_t      bdl_reg, bdl_next;
    slot_t      bidx_reg, bidx_next;
    period_t    bper_reg, bper_next;
    time_t      nd_reg, nd_next;
    slot_t      tgt_reg, tgt_next;
    logic       roll_reg, roll_next;
    result_t    res_reg, res_next;
    logic       more_reg, more_next;

    slot_t      rd_addr;
    time_t      rd_dl;
    period_t    rd_per;
    store_wr_t  wr;

    logic       ev, done, upd, f_fail, f_found, accept;
    slot_t      eidx, free_idx;
    logic       free_any;
    time_t      f_dl, start;
    period_t    f_per;
    slot_t      f_idx;
    slot_mask_t f_mask;

    dtt_store u_store (
        .clk         (clk),
        .rd_addr     (rd_addr),
        .rd_deadline (rd_dl),
        .rd_period   (rd_per),
        .wr          (wr)
    );

    assign cmd_in.ready  = (state_reg == S_IDLE);
    assign accept        = cmd_in.valid && cmd_in.ready;
    assign res_out.valid = out_v_reg;
    assign res_out.data  = out_reg;

    assign ev   = (cnt_reg != '0);
    assign done = (cnt_reg == CntW'(TimerSlots));
    assign eidx = cnt_reg[SlotW-1:0] - slot_t'(1);

    always_comb
    begin
        free_any = 1'b0;
        free_idx = '0;
        for (int i = TimerSlots - 1; i >= 0; i--)
        begin
            if (!active_reg[i])
            begin
                free_any = 1'b1;
                free_idx = slot_t'(i);
            end
        end
    end

    always_comb
    begin
        if (state_reg == S_IDLE)
        begin
            rd_addr = cmd_in.data.slot;
        end
        else
        begin
            rd_addr = cnt_reg[SlotW-1:0];
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        item_next     = item_reg;
        active_next   = active_reg;
        repeats_next  = repeats_reg;
        prev_now_next = prev_now_reg;
        notified_next = notified_reg;
        out_v_next    = out_v_reg;
        out_next      = out_reg;
        cnt_next      = cnt_reg;
        mask_next     = mask_reg;
        fail_next     = fail_reg;
        bfound_next   = bfound_reg;
        bdl_next      = bdl_reg;
        bidx_next     = bidx_reg;
        bper_next     = bper_reg;
        nd_next       = nd_reg;
        tgt_next      = tgt_reg;
        roll_next     = roll_reg;
        res_next      = res_reg;
        more_next     = more_reg;
        wr            = '0;
        start         = '0;

        f_fail  = fail_reg;
        upd     = 1'b0;
        f_found = bfound_reg;
        f_dl    = bdl_reg;
        f_idx   = bidx_reg;
        f_per   = bper_reg;
        f_mask  = mask_reg;

        if (res_out.ready)
        begin
            out_v_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    item_next  = cmd_in.data;
                    state_next = S_DECODE;
                end
            end

            S_DECODE:
            begin
                res_next   = '0;
                res_next.result_slot = item_reg.slot;
                res_next.last        = 1'b1;
                more_next  = 1'b0;
                state_next = S_OUT;
                cnt_next   = '0;
                fail_next  = 1'b0;
                bfound_next = 1'b0;
                case (item_reg.command)
                    CMD_ADD:
                    begin
                        if (free_any)
                        begin
                            nd_next = sat_add(item_reg.now_ms, item_reg.interval_ms);
                            tgt_next = free_idx;
                            wr.dl_en    = 1'b1;
                            wr.per_en   = 1'b1;
                            wr.addr     = free_idx;
                            wr.deadline = nd_next;
                            wr.period   = item_reg.interval_ms;
                            active_next[free_idx]  = 1'b1;
                            repeats_next[free_idx] = item_reg.recurring;
                            res_next.result_slot   = free_idx;
                            if (!notified_reg)
                            begin
                                state_next = S_NOTICE;
                            end
                        end
                        else
                        begin
                            res_next.status      = ST_FULL;
                            res_next.result_slot = '0;
                        end
                    end
                    CMD_CANCEL:
                    begin
                        if (active_reg[item_reg.slot])
                        begin
                            active_next[item_reg.slot] = 1'b0;
                        end
                        else
                        begin
                            res_next.status = ST_INACTIVE;
                        end
                    end
                    CMD_REFRESH:
                    begin
                        if (active_reg[item_reg.slot])
                        begin
                            wr.dl_en    = 1'b1;
                            wr.addr     = item_reg.slot;
                            wr.deadline = sat_add(item_reg.now_ms, rd_per);
                        end
                        else
                        begin
                            res_next.status = ST_INACTIVE;
                        end
                    end
                    CMD_RESET:
                    begin
                        if (item_reg.interval_ms == rd_per && !item_reg.restart_now)
                        begin
                            res_next.status = ST_OK;
                        end
                        else if (!active_reg[item_reg.slot])
                        begin
                            res_next.status = ST_INACTIVE;
                        end
                        else
                        begin
                            if (item_reg.restart_now)
                            begin
                                start = item_reg.now_ms;
                            end
                            else if (rd_dl >= {{(TimeW - PeriodW){1'b0}}, rd_per})
                            begin
                                start = rd_dl - {{(TimeW - PeriodW){1'b0}}, rd_per};
                            end
                            nd_next     = sat_add(start, item_reg.interval_ms);
                            tgt_next    = item_reg.slot;
                            wr.dl_en    = 1'b1;
                            wr.per_en   = 1'b1;
                            wr.addr     = item_reg.slot;
                            wr.deadline = nd_next;
                            wr.period   = item_reg.interval_ms;
                            if (!notified_reg)
                            begin
                                state_next = S_NOTICE;
                            end
                        end
                    end
                    CMD_COLLECT:
                    begin
                        res_next.result_slot = '0;
                        if (active_reg == '0)
                        begin
                            res_next.status = ST_INACTIVE;
                        end
                        else
                        begin
                            roll_next = (item_reg.now_ms < prev_now_reg) &&
                                ((prev_now_reg - item_reg.now_ms) >
                                 {{(TimeW - PeriodW){1'b0}}, window_reg});
                            prev_now_next = item_reg.now_ms;
                            mask_next     = '0;
                            state_next    = S_DUE;
                        end
                    end
                    CMD_QUERY:
                    begin
                        res_next.result_slot = '0;
                        notified_next = 1'b0;
                        if (active_reg == '0)
                        begin
                            res_next.wait_ms = TimeMax;
                        end
                        else
                        begin
                            mask_next  = active_reg;
                            state_next = S_MIN;
                        end
                    end
                    default:
                    begin
                        res_next.status      = ST_INACTIVE;
                        res_next.result_slot = '0;
                    end
                endcase
            end

            S_NOTICE:
            begin
                if (ev && eidx != tgt_reg && active_reg[eidx] &&
                    !(nd_reg < rd_dl || (nd_reg == rd_dl && tgt_reg < eidx)))
                begin
                    f_fail = 1'b1;
                end
                fail_next = f_fail;
                cnt_next  = cnt_reg + CntW'(1);
                if (done)
                begin
                    res_next.front_notice = !f_fail;
                    if (!f_fail)
                    begin
                        notified_next = 1'b1;
                    end
                    state_next = S_OUT;
                end
            end

            S_DUE:
            begin
                if (ev && active_reg[eidx] && (roll_reg || rd_dl <= item_reg.now_ms))
                begin
                    f_mask[eidx] = 1'b1;
                end
                mask_next = f_mask;
                cnt_next  = cnt_reg + CntW'(1);
                if (done)
                begin
                    cnt_next    = '0;
                    bfound_next = 1'b0;
                    if (f_mask == '0)
                    begin
                        res_next.status = ST_INACTIVE;
                        state_next = S_OUT;
                    end
                    else
                    begin
                        state_next = S_MIN;
                    end
                end
            end

            S_MIN:
            begin
                upd = ev && mask_reg[eidx] && (!bfound_reg || rd_dl < bdl_reg);
                if (upd)
                begin
                    f_found = 1'b1;
                    f_dl    = rd_dl;
                    f_idx   = eidx;
                    f_per   = rd_per;
                end
                bfound_next = f_found;
                bdl_next    = f_dl;
                bidx_next   = f_idx;
                bper_next   = f_per;
                cnt_next    = cnt_reg + CntW'(1);
                if (done)
                begin
                    state_next = S_OUT;
                    if (item_reg.command == CMD_QUERY)
                    begin
                        if (item_reg.now_ms < f_dl)
                        begin
                            res_next.wait_ms = f_dl - item_reg.now_ms;
                        end
                    end
                    else
                    begin
                        f_mask[f_idx] = 1'b0;
                        mask_next = f_mask;
                        if (repeats_reg[f_idx])
                        begin
                            wr.dl_en    = 1'b1;
                            wr.addr     = f_idx;
                            wr.deadline = sat_add(item_reg.now_ms, f_per);
                        end
                        else
                        begin
                            active_next[f_idx] = 1'b0;
                        end
                        res_next.status      = ST_OK;
                        res_next.result_slot = f_idx;
                        res_next.fired       = 1'b1;
                        res_next.last        = (f_mask == '0);
                        more_next            = (f_mask != '0);
                    end
                end
            end

            S_OUT:
            begin
                if (!out_v_reg || res_out.ready)
                begin
                    out_v_next = 1'b1;
                    out_next   = res_reg;
                    if (more_reg)
                    begin
                        cnt_next    = '0;
                        bfound_next = 1'b0;
                        state_next  = S_MIN;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            active_reg   <= '0;
            repeats_reg  <= '0;
            prev_now_reg <= '0;
            notified_reg <= 1'b0;
            window_reg   <= RolloverDefault;
            out_v_reg    <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            active_reg   <= active_next;
            repeats_reg  <= repeats_next;
            prev_now_reg <= prev_now_next;
            notified_reg <= notified_next;
            out_v_reg    <= out_v_next;
            if (cfg_we)
            begin
                window_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg   <= item_next;
        out_reg    <= out_next;
        cnt_reg    <= cnt_next;
        mask_reg   <= mask_next;
        fail_reg   <= fail_next;
        bfound_reg <= bfound_next;
        bdl_reg    <= bdl_next;
        bidx_reg   <= bidx_next;
        bper_reg   <= bper_next;
        nd_reg     <= nd_next;
        tgt_reg    <= tgt_next;
        roll_reg   <= roll_next;
        res_reg    <= res_next;
        more_reg   <= more_next;
    end

endmodule

>>> bench/deadline_timer_table_core_tb.sv
// ---------------------------------------------------------------------------
// deadline_timer_table_core_tb
// self-checking bench: drives timer commands through the valid/ready channel,
// predicts every result with a behavioral copy of the slot table, and checks
// results in order under random idling, a long output hold-off and config
// changes of the rollover window
// ---------------------------------------------------------------------------
module deadline_timer_table_core_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import dtt_pkg::*;

    class timer_scoreboard;
        logic       active [TimerSlots];
        logic       repeats [TimerSlots];
        period_t    period [TimerSlots];
        time_t      deadline [TimerSlots];
        time_t      prev_now;
        logic       notified;
        period_t    window;
        result_t    pending [$];
        int         errors;
        int         checked;

        function new();
            for (int i = 0; i < TimerSlots; i++)
            begin
                active[i] = 0;
                repeats[i] = 0;
                period[i] = '0;
                deadline[i] = '0;
            end
            prev_now = '0;
            notified = 0;
            window = RolloverDefault;
            errors = 0;
            checked = 0;
        endfunction

        function automatic time_t add_sat(time_t a, period_t b);
            logic [TimeW:0] s;
            s = {1'b0, a} + {{(TimeW + 1 - PeriodW){1'b0}}, b};
            return s[TimeW] ? TimeMax : s[TimeW-1:0];
        endfunction

        function automatic bit earlier(int a, int b);
            if (deadline[a] != deadline[b])
                return deadline[a] < deadline[b];
            return a < b;
        endfunction

        function automatic int first_active();
            int best;
            best = -1;
            for (int i = 0; i < TimerSlots; i++)
                if (active[i] && (best < 0 || earlier(i, best)))
                    best = i;
            return best;
        endfunction

        function automatic logic notice_for(int s);
            for (int i = 0; i < TimerSlots; i++)
                if (i != s && active[i] && !earlier(s, i))
                    return 0;
            if (notified)
                return 0;
            notified = 1;
            return 1;
        endfunction

        function automatic void push(status_t st, int sl, logic fi, time_t w, logic fn,
                                     logic la);
            result_t r;
            r.status = st;
            r.result_slot = sl[SlotW-1:0];
            r.fired = fi;
            r.wait_ms = w;
            r.front_notice = fn;
            r.last = la;
            pending.insert(pending.size(), r);
        endfunction

        function automatic bit period_is(int s, period_t v);
            return period[s] == v;
        endfunction

        function void note_command(item_t it);
            int s;
            int first;
            int n;
            int best;
            time_t start;
            slot_mask_t due;
            logic roll;
            s = int'(it.slot);
            case (it.command)
                CMD_ADD:
                begin
                    for (int i = 0; i < TimerSlots; i++)
                        if (!active[i])
                        begin
                            active[i] = 1;
                            repeats[i] = it.recurring;
                            period[i] = it.interval_ms;
                            deadline[i] = add_sat(it.now_ms, it.interval_ms);
                            push(ST_OK, i, 0, '0, notice_for(i), 1);
                            return;
                        end
                    push(ST_FULL, 0, 0, '0, 0, 1);
                end
                CMD_CANCEL:
                begin
                    if (active[s])
                    begin
                        active[s] = 0;
                        push(ST_OK, s, 0, '0, 0, 1);
                    end
                    else
                        push(ST_INACTIVE, s, 0, '0, 0, 1);
                end
                CMD_REFRESH:
                begin
                    if (active[s])
                    begin
                        deadline[s] = add_sat(it.now_ms, period[s]);
                        push(ST_OK, s, 0, '0, 0, 1);
                    end
                    else
                        push(ST_INACTIVE, s, 0, '0, 0, 1);
                end
                CMD_RESET:
                begin
                    if (period[s] == it.interval_ms && !it.restart_now)
                        push(ST_OK, s, 0, '0, 0, 1);
                    else if (!active[s])
                        push(ST_INACTIVE, s, 0, '0, 0, 1);
                    else
                    begin
                        if (it.restart_now)
                            start = it.now_ms;
                        else
                            start = deadline[s] >= time_t'(period[s]) ?
                                    deadline[s] - time_t'(period[s]) : '0;
                        period[s] = it.interval_ms;
                        deadline[s] = add_sat(start, it.interval_ms);
                        push(ST_OK, s, 0, '0, notice_for(s), 1);
                    end
                end
                CMD_COLLECT:
                begin
                    first = first_active();
                    if (first < 0)
                    begin
                        push(ST_INACTIVE, 0, 0, '0, 0, 1);
                        return;
                    end
                    roll = it.now_ms < prev_now && (prev_now - it.now_ms) > time_t'(window);
                    prev_now = it.now_ms;
                    due = '0;
                    for (int i = 0; i < TimerSlots; i++)
                        if (active[i] && (roll || deadline[i] <= it.now_ms))
                            due[i] = 1;
                    if (due == '0)
                    begin
                        push(ST_INACTIVE, 0, 0, '0, 0, 1);
                        return;
                    end
                    n = 0;
                    while (due != '0 && n < 16)
                    begin
                        best = -1;
                        for (int i = 0; i < TimerSlots; i++)
                            if (due[i] && (best < 0 || earlier(i, best)))
                                best = i;
                        due[best] = 0;
                        if (repeats[best])
                            deadline[best] = add_sat(it.now_ms, period[best]);
                        else
                            active[best] = 0;
                        push(ST_OK, best, 1, '0, 0, (due == '0 || n + 1 == 16));
                        n++;
                    end
                end
                CMD_QUERY:
                begin
                    first = first_active();
                    notified = 0;
                    if (first < 0)
                        push(ST_OK, 0, 0, TimeMax, 0, 1);
                    else if (it.now_ms >= deadline[first])
                        push(ST_OK, 0, 0, '0, 0, 1);
                    else
                        push(ST_OK, 0, 0, deadline[first] - it.now_ms, 0, 1);
                end
                default:
                    push(ST_INACTIVE, 0, 0, '0, 0, 1);
            endcase
        endfunction

        function void check_result(result_t got);
            result_t exp_r;
            if (pending.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result %p", got);
                return;
            end
            exp_r = pending.pop_front();
            checked++;
            if (got !== exp_r)
            begin
                errors++;
                if (errors <= 10)
                    $display("mismatch: expected %p, got %p", exp_r, got);
            end
        endfunction
    endclass

    logic clk = 0;
    logic rst_n = 0;
    logic cfg_we = 0;
    period_t cfg_wdata = '0;
    dtt_cmd_if cmd_bus();
    dtt_res_if res_bus();
    timer_scoreboard sb;
    bit quiet = 0;
    int hold_cycles = 0;
    time_t clock_ms = 48'd1000;

    deadline_timer_table_core u_dut (
        .clk(clk),
        .rst_n(rst_n),
        .cmd_in(cmd_bus.sink),
        .res_out(res_bus.source),
        .cfg_we(cfg_we),
        .cfg_wdata(cfg_wdata)
    );

    always #5 clk = ~clk;

    initial
    begin
        cmd_bus.valid = 0;
        cmd_bus.data = '0;
        res_bus.ready = 0;
    end

    // result side: random stall bursts and an optional long hold-off
    always @(posedge clk)
    begin
        if (rst_n && res_bus.valid && res_bus.ready)
            sb.check_result(res_bus.data);
        if (hold_cycles > 0)
        begin
            hold_cycles <= hold_cycles - 1;
            res_bus.ready <= 0;
        end
        else if (!quiet && $urandom_range(0, 9) == 0)
        begin
            hold_cycles <= $urandom_range(1, 15);
            res_bus.ready <= 0;
        end
        else
            res_bus.ready <= 1;
    end

    task automatic send(item_t it);
        int gap;
        if (!quiet && $urandom_range(0, 7) == 0)
        begin
            gap = $urandom_range(1, 15);
            cmd_bus.valid <= 0;
            repeat (gap) @(posedge clk);
        end
        cmd_bus.valid <= 1;
        cmd_bus.data <= it;
        @(posedge clk);
        while (!cmd_bus.ready)
            @(posedge clk);
        sb.note_command(it);
    endtask

    task automatic issue(command_t c, int s, period_t iv, logic rec, logic fnow, time_t t);
        item_t it;
        it.command = c;
        it.slot = s[SlotW-1:0];
        it.interval_ms = iv;
        it.recurring = rec;
        it.restart_now = fnow;
        it.now_ms = t;
        send(it);
    endtask

    task automatic drain();
        cmd_bus.valid <= 0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (400) @(posedge clk);
    endtask

    task automatic write_window(period_t v);
        @(posedge clk);
        cfg_we <= 1;
        cfg_wdata <= v;
        sb.window = v;
        @(posedge clk);
        cfg_we <= 0;
    endtask

    // slot to address: mostly an active one, so reset seldom reads a blank period
    function automatic int pick_slot();
        int s;
        for (int k = 0; k < 8; k++)
        begin
            s = $urandom_range(0, 15);
            if (sb.active[s])
                return s;
        end
        return s;
    endfunction

    task automatic random_item();
        int r;
        int s;
        period_t iv;
        item_t it;
        r = $urandom_range(0, 99);
        clock_ms = clock_ms + time_t'($urandom_range(0, 60));
        iv = ($urandom_range(0, 9) == 0) ? period_t'($urandom) : period_t'($urandom_range(0, 200));
        s = pick_slot();
        if (r < 30)
            issue(CMD_ADD, s, iv, 1'($urandom_range(0, 1)), 0, clock_ms);
        else if (r < 38)
            issue(CMD_CANCEL, s, iv, 0, 0, clock_ms);
        else if (r < 46)
            issue(CMD_REFRESH, s, iv, 0, 0, clock_ms);
        else if (r < 56)
        begin
            if (sb.active[s] || sb.period[s] != 0 || sb.deadline[s] != 0)
                issue(CMD_RESET, s, $urandom_range(0, 3) == 0 ? sb.period[s] : iv,
                      1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), clock_ms);
            else
                issue(CMD_RESET, s, iv, 0, 1, clock_ms);
        end
        else if (r < 80)
            issue(CMD_COLLECT, s, iv, 0, 0, clock_ms);
        else if (r < 94)
            issue(CMD_QUERY, s, iv, 0, 0, clock_ms);
        else if (r < 97)
        begin
            it = '0;
            it.command = 3'($urandom_range(6, 7));
            it.slot = 4'($urandom);
            it.interval_ms = $urandom;
            it.recurring = 1;
            it.restart_now = 1;
            it.now_ms = {16'($urandom), 32'($urandom)};
            send(it);
        end
        else
        begin
            clock_ms = clock_ms - time_t'($urandom_range(0, 5000));
            issue(CMD_COLLECT, s, iv, 0, 0, clock_ms);
        end
    endtask

    initial
    begin
        sb = new();
        repeat (8) @(posedge clk);
        rst_n <= 1;
        repeat (2) @(posedge clk);

        // directed: adds to fill, full table, field extremes, every command
        issue(CMD_QUERY, 0, 0, 0, 0, 48'd0);
        issue(CMD_COLLECT, 0, 0, 0, 0, 48'd0);
        issue(CMD_ADD, 0, 32'hFFFF_FFFF, 1, 0, TimeMax);
        issue(CMD_ADD, 0, 32'd0, 0, 0, 48'd100);
        issue(CMD_QUERY, 0, 0, 0, 0, 48'd50);
        for (int i = 0; i < 14; i++)
            issue(CMD_ADD, 0, 32'd10 + i, i % 2, 0, 48'd100);
        issue(CMD_ADD, 0, 32'd5, 0, 0, 48'd100);
        issue(CMD_CANCEL, 15, 0, 0, 0, 48'd100);
        issue(CMD_CANCEL, 15, 0, 0, 0, 48'd100);
        issue(CMD_REFRESH, 15, 0, 0, 0, 48'd100);
        issue(CMD_REFRESH, 3, 0, 0, 0, 48'd105);
        issue(CMD_RESET, 4, 32'd12, 0, 0, 48'd105);
        issue(CMD_RESET, 5, 32'd3, 0, 0, 48'd105);
        issue(CMD_RESET, 6, 32'd1, 0, 1, 48'd105);
        issue(CMD_RESET, 15, 32'd1, 0, 1, 48'd105);
        issue(CMD_COLLECT, 0, 0, 0, 0, 48'd200);
        issue(CMD_QUERY, 0, 0, 0, 0, 48'd200);
        drain();

        // rollover with the smallest window
        write_window('0);
        issue(CMD_ADD, 0, 32'd500, 1, 0, 48'd300);
        issue(CMD_COLLECT, 0, 0, 0, 0, 48'd199);
        drain();
        write_window(32'hFFFF_FFFF);
        clock_ms = 48'd2000;

        // long hold-off on results while commands keep coming
        @(negedge clk);
        hold_cycles = 300;
        @(posedge clk);
        for (int i = 0; i < 20; i++)
            random_item();
        // sender pauses until every result is in
        cmd_bus.valid <= 0;
        while (sb.pending.size() != 0)
            @(posedge clk);

        for (int i = 0; i < 35; i++)
            random_item();
        drain();
        write_window(32'd100);
        for (int i = 0; i < 30; i++)
            random_item();
        drain();
        write_window(RolloverDefault);
        quiet = 1;
        for (int i = 0; i < 15; i++)
            random_item();
        drain();

        $display("covered all commands, full table, rollover, four window settings");
        $display("results checked: %0d", sb.checked);
        if (sb.errors == 0)
            $display("deadline_timer_table_core_tb: done, clean");
        else
            $display("deadline_timer_table_core_tb: done, errors");
        $finish;
    end

    initial
    begin
        #5ms;
        $display("deadline_timer_table_core_tb: done, errors");
        $finish;
    end
endmodule
